// File: src/xs128_pkg.sv
package xs128_pkg;

  localparam int unsigned WordW = 64;

  // Fallback seed used when both seed words are zero
  localparam logic [WordW-1:0] DefaultSeedA = 64'h0123_4567_89AB_CDEF;
  localparam logic [WordW-1:0] DefaultSeedB = 64'hDEAD_BEEF_DEAD_BEEF;

  // Jump polynomial, low word in bits 63:0
  localparam logic [2*WordW-1:0] JumpPoly = {64'h121f_d215_5c47_2f96, 64'h8a5c_d789_635d_2dff};
  localparam int unsigned JumpStepW = 7;

  localparam int unsigned RotAmt    = 17;
  localparam int unsigned ShlAmt    = 23;
  localparam int unsigned ShrAmtA   = 18;
  localparam int unsigned ShrAmtB   = 5;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } pair_t;

  // Request to the jump unit
  typedef struct packed {
    logic  start;
    pair_t base;
  } jump_ctrl_t;

  // Status from the jump unit; result is valid while done is high
  typedef struct packed {
    logic  done;
    pair_t result;
  } jump_stat_t;

  // One xorshift128 state advance
  function automatic pair_t advance_pair(input pair_t p);
    logic [WordW-1:0] t;
    pair_t            r;
    t   = p.a ^ (p.a << ShlAmt);
    t   = t ^ (t >> ShrAmtA);
    r.a = p.b;
    r.b = t ^ p.b ^ (p.b >> ShrAmtB);
    return r;
  endfunction

  function automatic logic [WordW-1:0] rotl17(input logic [WordW-1:0] x);
    return {x[WordW-1-RotAmt:0], x[WordW-1:WordW-RotAmt]};
  endfunction

endpackage

// File: src/xs128_jump.sv
module xs128_jump
  import xs128_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jump_ctrl_t ctrl_i,
  output jump_stat_t stat_o
);

  pair_t                cur_q;
  pair_t                acc_q;
  pair_t                cur_adv;
  pair_t                acc_next;
  logic [JumpStepW-1:0] cnt_q;
  logic                 busy_q;
  logic                 last_step;

  // One polynomial bit per cycle: accumulate, then advance the walking state
  assign cur_adv   = advance_pair(cur_q);
  assign acc_next  = JumpPoly[cnt_q] ? (acc_q ^ cur_q) : acc_q;
  assign last_step = busy_q && (&cnt_q);

  assign stat_o.done   = last_step;
  assign stat_o.result = acc_next;

  // Control: busy flag and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + JumpStepW'(1);
      if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: walking state and accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cur_q <= ctrl_i.base;
      acc_q <= '0;
    end else if (busy_q) begin
      cur_q <= cur_adv;
      acc_q <= acc_next;
    end
  end

endmodule

// File: src/xorshift128pp_four_lane_generator_top.sv
// Draw with a filled buffer: result registered; one draw per cycle sustained while the output is taken.
// Draw on an empty buffer: accept, lane step, output mix, output load (held until the output is free),
// once per LANES draws.
// Seed: lane 0 loads, then the bit-serial jump unit walks 128 poly bits per further lane.
// Reset: async active low; afterwards the block seeds itself from the default seed,
// not ready until seeding ends; the output buffer starts empty.
module xorshift128pp_four_lane_generator_top
  import xs128_pkg::*;
#(
  parameter int unsigned LANES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [WordW-1:0] seed_first_i,
  input  logic [WordW-1:0] seed_second_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] value_o
);

  localparam int unsigned LaneIdxW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PosW     = $clog2(LANES + 1);
  localparam logic [PosW-1:0]     PosEmpty = PosW'(LANES);
  localparam logic [LaneIdxW-1:0] LastLane = LaneIdxW'(LANES - 1);
  localparam bit                  MultiLane = (LANES > 1);

  typedef enum logic [5:0] {
    StInit = 6'b000001,
    StIdle = 6'b000010,
    StStep = 6'b000100,
    StMix  = 6'b001000,
    StSend = 6'b010000,
    StJump = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [LaneIdxW-1:0]  lane_idx_q, lane_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [WordW-1:0]     value_q;

  pair_t                lane_q [LANES];
  logic [WordW-1:0]     buf_q  [LANES];

  jump_ctrl_t           jctrl;
  jump_stat_t           jstat;

  logic                 in_fire, seed_fire, draw_fire, hit;
  logic                 out_free, out_load;
  logic                 seed_zero, load_lane0;
  pair_t                seed_pair;
  logic [WordW-1:0]     out_data;

  xs128_jump u_jump (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (jctrl),
    .stat_o (jstat)
  );

  // Handshake decode
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign seed_fire  = in_fire && op_i;
  assign draw_fire  = in_fire && !op_i;
  assign hit        = draw_fire && (pos_q != PosEmpty);
  assign out_load   = hit || ((state_q == StSend) && out_free);
  assign out_data   = (state_q == StSend) ? buf_q[0] : buf_q[pos_q[LaneIdxW-1:0]];

  // Seed select: all-zero seed falls back to the default
  assign seed_zero   = (seed_first_i == '0) && (seed_second_i == '0);
  assign seed_pair.a = (seed_zero || (state_q == StInit)) ? DefaultSeedA : seed_first_i;
  assign seed_pair.b = (seed_zero || (state_q == StInit)) ? DefaultSeedB : seed_second_i;
  assign load_lane0  = (state_q == StInit) || seed_fire;

  // Jump unit requests: chain each lane from the previous result
  always_comb begin
    jctrl.start = 1'b0;
    jctrl.base  = seed_pair;
    if (load_lane0) begin
      jctrl.start = MultiLane;
    end else if ((state_q == StJump) && jstat.done && (lane_idx_q != LastLane)) begin
      jctrl.start = 1'b1;
      jctrl.base  = jstat.result;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    lane_idx_d  = lane_idx_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StInit: begin
        pos_d      = PosEmpty;
        lane_idx_d = LaneIdxW'(1);
        state_d    = MultiLane ? StJump : StIdle;
      end
      StIdle: begin
        if (seed_fire) begin
          pos_d      = PosEmpty;
          lane_idx_d = LaneIdxW'(1);
          state_d    = MultiLane ? StJump : StIdle;
        end else if (hit) begin
          pos_d = pos_q + PosW'(1);
        end else if (draw_fire) begin
          state_d = StStep;
        end
      end
      StStep: state_d = StMix;
      StMix:  state_d = StSend;
      StSend: begin
        if (out_free) begin
          pos_d   = PosW'(1);
          state_d = StIdle;
        end
      end
      StJump: begin
        if (jstat.done) begin
          if (lane_idx_q == LastLane) begin
            state_d = StIdle;
          end else begin
            lane_idx_d = lane_idx_q + LaneIdxW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      pos_q       <= PosEmpty;
      lane_idx_q  <= LaneIdxW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      lane_idx_q  <= lane_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q <= out_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // Lane state: lane 0 load, jump results, parallel step
  always_ff @(posedge clk_i) begin
    if (load_lane0) begin
      lane_q[0] <= seed_pair;
    end else if ((state_q == StJump) && jstat.done) begin
      lane_q[lane_idx_q] <= jstat.result;
    end else if (state_q == StStep) begin
      for (int i = 0; i < LANES; i++) begin
        lane_q[i] <= advance_pair(lane_q[i]);
      end
    end
  end

  // Output buffer: sum a+b before the step, then rotate and add old b (now word a)
  always_ff @(posedge clk_i) begin
    if (state_q == StStep) begin
      for (int i = 0; i < LANES; i++) begin
        buf_q[i] <= lane_q[i].a + lane_q[i].b;
      end
    end else if (state_q == StMix) begin
      for (int i = 0; i < LANES; i++) begin
        buf_q[i] <= rotl17(buf_q[i]) + lane_q[i].a;
      end
    end
  end

`ifndef SYNTH
  // Buffer position never runs past empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosEmpty)
    else $error("buffer position out of range");

  // Jump results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni) jstat.done |-> (state_q == StJump))
    else $error("jump unit finished outside seeding");

  // A new item is never taken while the output register would be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_ready_o |-> (!out_valid_q || out_ready_i))
    else $error("input ready while output stalled");

  // A refill always ends in a transfer attempt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StMix) |=> (state_q == StSend))
    else $error("refill did not reach send");
`endif

endmodule

// File: tb/sv/xs128_tb_pkg.sv
package xs128_tb_pkg;

  // Item operation codes on op_i
  typedef enum logic {
    OpDraw = 1'b0,
    OpSeed = 1'b1
  } gen_op_e;

endpackage

// File: tb/sv/xs128_gen_checker.sv
module xs128_gen_checker
  import xs128_pkg::*;
  import xs128_tb_pkg::*;
#(
  parameter int unsigned LANES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             op_i,
  input  logic [WordW-1:0] seed_first_i,
  input  logic [WordW-1:0] seed_second_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [WordW-1:0] value_i,
  output int               errors_o,
  output int               pending_o
);

  typedef logic [WordW-1:0] word_t;

  // Shadow copy of the lane state and the output buffer
  word_t       lane_a [LANES];
  word_t       lane_b [LANES];
  word_t       mix_buf[LANES];
  int unsigned mix_pos;
  word_t       value_q[$];
  int          fail_cnt = 0;

  // One xorshift128 state advance
  function automatic void xs_advance(inout word_t a, inout word_t b);
    word_t t;
    t = a ^ (a << ShlAmt);
    t = t ^ (t >> ShrAmtA);
    a = b;
    b = t ^ b ^ (b >> ShrAmtB);
  endfunction

  // Lane state after the jump polynomial is applied to (a, b)
  function automatic void jump_lane(input word_t a, input word_t b,
                                    output word_t ja, output word_t jb);
    word_t acc_a;
    word_t acc_b;
    acc_a = '0;
    acc_b = '0;
    for (int k = 0; k < 2 * WordW; k++) begin
      if (JumpPoly[k]) begin
        acc_a ^= a;
        acc_b ^= b;
      end
      xs_advance(a, b);
    end
    ja = acc_a;
    jb = acc_b;
  endfunction

  // Load lane 0 and derive the others; the buffer is emptied
  function void reseed_lanes(input word_t sa, input word_t sb);
    if (sa == '0 && sb == '0) begin
      sa = DefaultSeedA;
      sb = DefaultSeedB;
    end
    lane_a[0] = sa;
    lane_b[0] = sb;
    for (int i = 1; i < LANES; i++) begin
      jump_lane(lane_a[i-1], lane_b[i-1], lane_a[i], lane_b[i]);
    end
    mix_pos = LANES;
  endfunction

  // Step every lane at once and refill the buffer
  function void refill_mix();
    word_t a;
    word_t b;
    word_t s;
    for (int i = 0; i < LANES; i++) begin
      a = lane_a[i];
      b = lane_b[i];
      s = a + b;
      mix_buf[i] = {s[WordW-1-RotAmt:0], s[WordW-1:WordW-RotAmt]} + b;
      xs_advance(a, b);
      lane_a[i] = a;
      lane_b[i] = b;
    end
  endfunction

  // Compare result transfers first, then predict from the input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    if (!rst_ni) begin
      reseed_lanes('0, '0);
      value_q.delete();
      pending_o <= 0;
      errors_o  <= fail_cnt;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (value_q.size() == 0) begin
          $error("value: expected none, actual %h", value_i);
          fail_cnt++;
        end else begin
          want = value_q.pop_front();
          if (value_i !== want) begin
            $error("value: expected %h, actual %h", want, value_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OpSeed) begin
          reseed_lanes(seed_first_i, seed_second_i);
        end else begin
          if (mix_pos >= LANES) begin
            refill_mix();
            mix_pos = 0;
          end
          value_q.push_back(mix_buf[mix_pos]);
          mix_pos++;
        end
      end
      pending_o <= value_q.size();
      errors_o  <= fail_cnt;
    end
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  import xs128_pkg::*;
  import xs128_tb_pkg::*;

  localparam int unsigned LANES     = 4;
  localparam int          SeedCyc   = 1 + 128 * (LANES - 1);
  localparam int          IdleLimit = 2000;
  localparam int          NumRandom = 1625;

  typedef logic [WordW-1:0] word_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  logic  op        = OpDraw;
  word_t seed_first  = '0;
  word_t seed_second = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t value;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always #2 clk_i = ~clk_i;

  xorshift128pp_four_lane_generator_top #(
    .LANES(LANES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .seed_first_i (seed_first),
    .seed_second_i(seed_second),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_o      (value)
  );

  xs128_gen_checker #(
    .LANES(LANES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .seed_first_i (seed_first),
    .seed_second_i(seed_second),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .value_i      (value),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stall before each transfer, bursts without stalls
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
    end
  end

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(input gen_op_e kind, input word_t sa, input word_t sb);
    int gap;
    @(negedge clk_i);
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    seed_first  <= sa;
    seed_second <= sb;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Seed words of varied shape: random, zero halves, all ones, single bit
  task automatic send_random_seed();
    word_t sa;
    word_t sb;
    sa = rand_word();
    sb = rand_word();
    case ($urandom_range(0, 5))
      0: begin
        sa = '0;
        sb = '0;
      end
      1: sa = '0;
      2: sb = '0;
      3: begin
        sa = '1;
        sb = '1;
      end
      4: begin
        sa = word_t'(1) << $urandom_range(0, WordW - 1);
        sb = word_t'(1) << $urandom_range(0, WordW - 1);
      end
      default: ;
    endcase
    send_item(OpSeed, sa, sb);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: buffer refill from the reset state, each seed shape
    repeat (6) send_item(OpDraw, '0, '0);
    send_item(OpSeed, '0, '0);
    repeat (2) send_item(OpDraw, '0, '0);
    send_item(OpSeed, '1, '1);
    repeat (5) send_item(OpDraw, '0, '0);
    send_item(OpSeed, word_t'(1), '0);
    send_item(OpDraw, '0, '0);
    send_item(OpSeed, '0, word_t'(1));
    send_item(OpDraw, '0, '0);
    send_item(OpSeed, {1'b1, {(WordW-1){1'b0}}}, {1'b1, {(WordW-1){1'b0}}});
    send_item(OpDraw, '1, '1);

    // Random: mostly draws with junk seed fields, occasional reseed
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) begin
        send_random_seed();
      end else begin
        send_item(OpDraw, rand_word(), rand_word());
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // Drain, then let any trailing seed finish
    while (pending != 0) @(posedge clk_i);
    repeat (SeedCyc + 16) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
